// File: rtl/core/block_gain_rms_meter_macros.svh
// Assertion macros for the gain and RMS level meter.
`ifndef BLOCK_GAIN_RMS_METER_MACROS_SVH
`define BLOCK_GAIN_RMS_METER_MACROS_SVH
`ifndef SYNTHESIS
`define BGRM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define BGRM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define BGRM_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define BGRM_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/core/bgrm_pkg.sv
// Shared types and constants of the gain and RMS level meter.
`default_nettype none
package bgrm_pkg;
    localparam int SAMPLE_W      = 16;
    localparam int GAIN_W        = 16;
    localparam int SUM_W         = 41;
    localparam int SQ_W          = 31;
    localparam int ROOT_W        = 21;
    localparam int DIV_STEPS     = SUM_W;
    localparam int SQRT_STEPS    = ROOT_W;
    localparam int STEP_W        = 6;
    localparam int MAX_BLOCK_DEF = 960;
    localparam int DATA_W        = 32;
    localparam int USER_W        = 2;
    localparam int PADDR_W       = 3;
    localparam int PDATA_W       = 32;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd16384;
    // register index taken from paddr[2]
    localparam logic REG_VOLUME_GAIN = 1'b0;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_SQR,
        ST_ACC,
        ST_DLOAD,
        ST_DIV,
        ST_SQLOAD,
        ST_SQRT,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic capture;
        logic mul;
        logic sqr;
        logic acc;
        logic div_load;
        logic div_step;
        logic sq_load;
        logic sq_step;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic counted;
        logic eob;
        logic count_zero;
        logic out_free;
    } t_sts;
endpackage
`default_nettype wire

// File: rtl/core/bgrm_regs.sv
// APB register file: the volume gain register.
`default_nettype none
module bgrm_regs (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_psel,
    input  wire logic                          i_penable,
    input  wire logic                          i_pwrite,
    input  wire logic [bgrm_pkg::PADDR_W-1:0]  i_paddr,
    input  wire logic [bgrm_pkg::PDATA_W-1:0]  i_pwdata,
    output logic      [bgrm_pkg::PDATA_W-1:0]  o_prdata,
    output logic                               o_pready,
    output logic      [bgrm_pkg::GAIN_W-1:0]   o_gain
);
    logic [bgrm_pkg::GAIN_W-1:0] r_gain;
    logic                        w_sel_gain;

    assign w_sel_gain = (i_paddr[2] == bgrm_pkg::REG_VOLUME_GAIN);
    assign o_pready   = 1'b1;
    assign o_gain     = r_gain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= bgrm_pkg::GAIN_RESET;
        end else if (i_psel && i_penable && i_pwrite && w_sel_gain) begin
            r_gain <= i_pwdata[bgrm_pkg::GAIN_W-1:0];
        end
    end

    always_comb begin
        o_prdata = '0;
        if (w_sel_gain) begin
            o_prdata = {{(bgrm_pkg::PDATA_W-bgrm_pkg::GAIN_W){1'b0}}, r_gain};
        end
    end
endmodule
`default_nettype wire

// File: rtl/core/bgrm_datapath.sv
// Datapath: gain multiply, square-accumulate, restoring divider, digit-wise root.
`default_nettype none
module bgrm_datapath #(
    parameter int MAX_BLOCK = bgrm_pkg::MAX_BLOCK_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire bgrm_pkg::t_cmd                  i_cmd,
    output bgrm_pkg::t_sts                       o_sts,
    input  wire logic signed [bgrm_pkg::SAMPLE_W-1:0] i_sample,
    input  wire logic                            i_eob,
    input  wire logic [bgrm_pkg::GAIN_W-1:0]     i_gain,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic [bgrm_pkg::DATA_W-1:0]          o_out_data,
    output logic [bgrm_pkg::USER_W-1:0]          o_out_user
);
    localparam int CNT_W = $clog2(MAX_BLOCK + 1);
    localparam int SW    = bgrm_pkg::SUM_W;
    localparam int RW    = bgrm_pkg::ROOT_W;
    localparam int REM_W = RW + 2;

    // input capture
    logic signed [15:0] r_sample;
    logic               r_eob;
    logic               r_counted;
    // gain and square stages
    logic signed [32:0] r_prod;
    logic signed [15:0] r_scaled;
    logic [bgrm_pkg::SQ_W-1:0] r_square;
    // block state
    logic [SW-1:0]      r_sum;
    logic [CNT_W-1:0]   r_count;
    // divider
    logic [SW-1:0]      r_quo;
    logic [CNT_W-1:0]   r_divisor;
    logic [CNT_W-1:0]   r_rem;
    // square root
    logic [SW:0]        r_val;
    logic [REM_W-1:0]   r_srem;
    logic [RW-1:0]      r_root;
    // output register
    logic               r_out_valid;
    logic [bgrm_pkg::DATA_W-1:0] r_out_data;
    logic [bgrm_pkg::USER_W-1:0] r_out_user;

    logic signed [32:0] w_prod;
    logic signed [33:0] w_rnd;
    logic signed [19:0] w_q;
    logic signed [15:0] w_scaled;
    logic [15:0]        w_mag;
    logic [31:0]        w_sq;
    logic [SW:0]        w_sum_ext;
    logic [CNT_W:0]     w_dsh;
    logic [CNT_W:0]     w_ddiff;
    logic               w_dge;
    logic [REM_W+1:0]   w_ssh;
    logic [REM_W+1:0]   w_trial;
    logic [REM_W+1:0]   w_sdiff;
    logic               w_sge;
    logic [15:0]        w_level;

    assign w_prod = r_sample * $signed({1'b0, i_gain});

    // round half up, floor shift by 14, saturate to Q1.15
    assign w_rnd = {r_prod[32], r_prod} + 34'sd8192;
    assign w_q   = w_rnd[33:14];
    always_comb begin
        if (w_q > 20'sd32767) begin
            w_scaled = 16'sh7fff;
        end else if (w_q < -20'sd32768) begin
            w_scaled = 16'sh8000;
        end else begin
            w_scaled = w_q[15:0];
        end
    end
    assign w_mag = w_scaled[15] ? 16'(-w_scaled) : w_scaled;
    assign w_sq  = w_mag * w_mag;

    assign w_sum_ext = {1'b0, r_sum} + {{(SW+1-bgrm_pkg::SQ_W){1'b0}}, r_square};

    assign w_dsh   = {r_rem, r_quo[SW-1]};
    assign w_ddiff = w_dsh - {1'b0, r_divisor};
    assign w_dge   = (w_dsh >= {1'b0, r_divisor});

    assign w_ssh   = {r_srem, r_val[SW:SW-1]};
    assign w_trial = {{(REM_W+2-RW-2){1'b0}}, r_root, 2'b01};
    assign w_sdiff = w_ssh - w_trial;
    assign w_sge   = (w_ssh >= w_trial);

    assign w_level = (r_root[RW-1:16] != '0) ? 16'hffff : r_root[15:0];

    assign o_sts.counted    = r_counted;
    assign o_sts.eob        = r_eob;
    assign o_sts.count_zero = (r_count == '0);
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_user  = r_out_user;

    // block state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.acc && r_counted) begin
                r_sum   <= w_sum_ext[SW] ? {SW{1'b1}} : w_sum_ext[SW-1:0];
                r_count <= r_count + CNT_W'(1);
            end else if (i_cmd.div_load) begin
                r_sum   <= '0;
                r_count <= '0;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_sample  <= i_sample;
            r_eob     <= i_eob;
            r_counted <= (r_count < CNT_W'(MAX_BLOCK));
        end
        if (i_cmd.mul) begin
            r_prod <= w_prod;
        end
        if (i_cmd.sqr) begin
            r_scaled <= w_scaled;
            r_square <= w_sq[bgrm_pkg::SQ_W-1:0];
        end
        if (i_cmd.div_load) begin
            r_quo     <= r_sum;
            r_divisor <= r_count;
            r_rem     <= '0;
            r_root    <= '0;
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[SW-2:0], w_dge};
            r_rem <= w_dge ? w_ddiff[CNT_W-1:0] : w_dsh[CNT_W-1:0];
        end
        if (i_cmd.sq_load) begin
            r_val  <= {1'b0, r_quo};
            r_srem <= '0;
            r_root <= '0;
        end else if (i_cmd.sq_step) begin
            r_val  <= {r_val[SW-2:0], 2'b00};
            r_srem <= w_sge ? w_sdiff[REM_W-1:0] : w_ssh[REM_W-1:0];
            r_root <= {r_root[RW-2:0], w_sge};
        end
        if (i_cmd.load_out) begin
            r_out_data <= {(r_eob ? w_level : 16'd0),
                           (r_counted ? r_scaled : 16'sd0)};
            r_out_user <= {r_eob, r_counted};
        end
    end
endmodule
`default_nettype wire

// File: rtl/core/bgrm_ctrl.sv
// Controller: sequences one sample through the datapath.
`default_nettype none
`include "block_gain_rms_meter_macros.svh"
module bgrm_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire bgrm_pkg::t_sts  i_sts,
    output bgrm_pkg::t_cmd       o_cmd
);
    bgrm_pkg::t_state r_state;
    bgrm_pkg::t_state n_state;
    logic [bgrm_pkg::STEP_W-1:0] r_step;
    logic [bgrm_pkg::STEP_W-1:0] n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bgrm_pkg::ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_step  = '0;
        case (r_state)
            bgrm_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = bgrm_pkg::ST_MUL;
                end
            end
            bgrm_pkg::ST_MUL: begin
                n_state = bgrm_pkg::ST_SQR;
            end
            bgrm_pkg::ST_SQR: begin
                n_state = bgrm_pkg::ST_ACC;
            end
            bgrm_pkg::ST_ACC: begin
                if (i_sts.eob) begin
                    n_state = bgrm_pkg::ST_DLOAD;
                end else if (i_sts.counted) begin
                    n_state = bgrm_pkg::ST_OUT;
                end else begin
                    n_state = bgrm_pkg::ST_IDLE;
                end
            end
            bgrm_pkg::ST_DLOAD: begin
                n_state = i_sts.count_zero ? bgrm_pkg::ST_OUT : bgrm_pkg::ST_DIV;
            end
            bgrm_pkg::ST_DIV: begin
                if (r_step == bgrm_pkg::STEP_W'(bgrm_pkg::DIV_STEPS - 1)) begin
                    n_state = bgrm_pkg::ST_SQLOAD;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            bgrm_pkg::ST_SQLOAD: begin
                n_state = bgrm_pkg::ST_SQRT;
            end
            bgrm_pkg::ST_SQRT: begin
                if (r_step == bgrm_pkg::STEP_W'(bgrm_pkg::SQRT_STEPS - 1)) begin
                    n_state = bgrm_pkg::ST_OUT;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            bgrm_pkg::ST_OUT: begin
                if (i_sts.out_free) begin
                    n_state = bgrm_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = bgrm_pkg::ST_IDLE;
            end
        endcase
    end

    // commands
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            bgrm_pkg::ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            bgrm_pkg::ST_MUL:    o_cmd.mul      = 1'b1;
            bgrm_pkg::ST_SQR:    o_cmd.sqr      = 1'b1;
            bgrm_pkg::ST_ACC:    o_cmd.acc      = 1'b1;
            bgrm_pkg::ST_DLOAD:  o_cmd.div_load = 1'b1;
            bgrm_pkg::ST_DIV:    o_cmd.div_step = 1'b1;
            bgrm_pkg::ST_SQLOAD: o_cmd.sq_load  = 1'b1;
            bgrm_pkg::ST_SQRT:   o_cmd.sq_step  = 1'b1;
            bgrm_pkg::ST_OUT:    o_cmd.load_out = i_sts.out_free;
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    `BGRM_ASSERT_IMP(a_div_range, i_clk, i_rst_n, r_state == bgrm_pkg::ST_DIV, r_step < bgrm_pkg::STEP_W'(bgrm_pkg::DIV_STEPS))
    `BGRM_ASSERT_IMP(a_sqrt_range, i_clk, i_rst_n, r_state == bgrm_pkg::ST_SQRT, r_step < bgrm_pkg::STEP_W'(bgrm_pkg::SQRT_STEPS))
    `BGRM_ASSERT_IMP(a_load_free, i_clk, i_rst_n, o_cmd.load_out, i_sts.out_free)
    `BGRM_ASSERT_NXT(a_capture_mul, i_clk, i_rst_n, o_cmd.capture, r_state == bgrm_pkg::ST_MUL)
    `BGRM_ASSERT_NXT(a_root_done, i_clk, i_rst_n, (r_state == bgrm_pkg::ST_SQRT) && (r_step == bgrm_pkg::STEP_W'(bgrm_pkg::SQRT_STEPS - 1)), r_state == bgrm_pkg::ST_OUT)
endmodule
`default_nettype wire

// File: rtl/core/block_gain_rms_meter.sv
// Gain stage with per-block RMS level meter: top level.
// Input stream: s_axis_tdata[15:0] carries a signed Q1.15 sample, s_axis_tlast marks
// the last sample of a block. Output stream: m_axis_tdata holds the scaled sample
// (low half, 0 when not counted) and the block level (high half, 0 except on the
// block's last beat); m_axis_tuser[0] flags a counted sample, [1] a valid level.
// The gain register (Q2.14, unity 16384) sits at APB address 0; write it only idle.
// One sample at a time: s_axis_tready is high only while the controller is idle.
// From acceptance, a mid-block sample goes through capture, multiply, square,
// accumulate and output load before the next beat can be taken; its result is in
// the output register after the output load. A last sample adds a divider load,
// a one-bit-per-cycle divider for sum/count, a root load and a digit-by-digit
// square root before the output load. Samples past the block limit are
// dropped; without tlast they produce no output beat.
// Reset clears the gain to unity, the accumulator, the count and the output valid.
// A stalled m_axis_tready holds the output beat; the block still accepts the next
// sample and works on it, waiting only when its own result is ready to load.
`default_nettype none
module block_gain_rms_meter #(
    parameter int MAX_BLOCK = bgrm_pkg::MAX_BLOCK_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // APB configuration
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [bgrm_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [bgrm_pkg::PDATA_W-1:0]   pwdata,
    output logic      [bgrm_pkg::PDATA_W-1:0]   prdata,
    output logic                                pready,
    // sample in
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [15:0]                    s_axis_tdata,  // [15:0] sample_in
    input  wire logic                           s_axis_tlast,  // end_of_block
    // result out
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    output logic [bgrm_pkg::DATA_W-1:0]         m_axis_tdata,  // [15:0] scaled_sample,
                                                               // [31:16] block_level
    output logic [bgrm_pkg::USER_W-1:0]         m_axis_tuser   // [0] sample_valid,
                                                               // [1] level_valid
);
    bgrm_pkg::t_cmd              w_cmd;
    bgrm_pkg::t_sts              w_sts;
    logic [bgrm_pkg::GAIN_W-1:0] w_gain;

    bgrm_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready),
        .o_gain    (w_gain)
    );

    bgrm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    bgrm_datapath #(
        .MAX_BLOCK (MAX_BLOCK)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_sample    ($signed(s_axis_tdata)),
        .i_eob       (s_axis_tlast),
        .i_gain      (w_gain),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata),
        .o_out_user  (m_axis_tuser)
    );
endmodule
`default_nettype wire
